// ===== hdl/rmq_pkg.sv =====
// Package with the constants, codes and types of the rotation matrix to quaternion block.
`timescale 1ns / 1ps
`default_nettype none
package rmq_pkg;

  // Fixed point format of matrix entries and quaternion parts.
  localparam int FracBits = 14;
  localparam int SqrtFrac = 24;

  // Radicand: one plus up to three entries, held signed.
  localparam int RW    = 19;
  localparam int RMagW = 17;

  // Square root operand and pipeline widths.
  localparam int NShift    = 2 * SqrtFrac - FracBits;
  localparam int NW        = ((RMagW + NShift + 1) / 2) * 2;
  localparam int SqStages  = NW / 2;
  localparam int HW        = SqStages;
  localparam int SqRemW    = HW + 2;

  // Branch component rounding shift.
  localparam int RoundSh = SqrtFrac + 1 - FracBits;

  // Off-diagonal sums and differences, and the divider.
  localparam int DW      = 18;
  localparam int MagW    = 17;
  localparam int QW      = 24;
  localparam int NumW    = MagW + SqrtFrac + 1;
  localparam int DvW     = HW + 1;

  // Output saturation limit.
  localparam int LimInt = ((1 << FracBits) > 32767) ? 32767 : (1 << FracBits);
  localparam logic [15:0] Lim = 16'(LimInt);

  // Branch codes: which component is taken from the square root.
  localparam logic [1:0] BrW = 2'd0;
  localparam logic [1:0] BrX = 2'd1;
  localparam logic [1:0] BrY = 2'd2;
  localparam logic [1:0] BrZ = 2'd3;

  // Item tag carried through the square root pipeline.
  typedef struct packed {
    logic            bad;
    logic [1:0]      br;
    logic [2:0]      neg;
    logic [MagW-1:0] mag0;
    logic [MagW-1:0] mag1;
    logic [MagW-1:0] mag2;
  } sq_tag_t;

  // Item tag carried through the divider pipeline.
  typedef struct packed {
    logic           bad;
    logic [1:0]     br;
    logic [2:0]     neg;
    logic [15:0]    quarter;
    logic [DvW-1:0] dvsr;
  } dv_tag_t;

  // Saturate an unsigned quotient to the output limit.
  function automatic logic [15:0] sat_q(input logic [QW-1:0] q);
    logic [15:0] res;
    if (q > QW'(LimInt)) res = Lim;
    else res = q[15:0];
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/rotation_matrix_to_quaternion.sv =====
// Top level: pipelined rotation matrix to unit quaternion converter (four-branch method).
`timescale 1ns / 1ps
`default_nettype none
// A new matrix may be started in every clock cycle; busy is always low. Each result
// appears on the out_ ports for one cycle with out_valid, in the order the matrices
// came in. Each matrix passes through the square root, which resolves one root bit
// per stage over 26 stages, and then the three parallel dividers, which resolve one
// quotient bit per stage over 24 stages. The receiver cannot stall the block; every
// result must be taken when it is shown.
module rotation_matrix_to_quaternion (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  wire signed [15:0] in_m00,
  input  wire signed [15:0] in_m01,
  input  wire signed [15:0] in_m02,
  input  wire signed [15:0] in_m10,
  input  wire signed [15:0] in_m11,
  input  wire signed [15:0] in_m12,
  input  wire signed [15:0] in_m20,
  input  wire signed [15:0] in_m21,
  input  wire signed [15:0] in_m22,
  output logic              out_valid,
  output logic signed [15:0] out_qw,
  output logic signed [15:0] out_qx,
  output logic signed [15:0] out_qy,
  output logic signed [15:0] out_qz,
  output logic              out_bad_input
);

  localparam int SqS = rmq_pkg::SqStages;
  localparam int QW  = rmq_pkg::QW;
  localparam int HW  = rmq_pkg::HW;
  localparam int DvW = rmq_pkg::DvW;
  localparam int NW  = rmq_pkg::NW;
  localparam int RW  = rmq_pkg::RW;
  localparam int DW  = rmq_pkg::DW;
  localparam int MagW = rmq_pkg::MagW;
  localparam int NumW = rmq_pkg::NumW;
  localparam int SqRemW = rmq_pkg::SqRemW;
  localparam int LimOne = 1 << rmq_pkg::FracBits;

  // The block never holds off a transaction.
  assign busy = 1'b0;

  // Input capture stage.
  logic               in_vld_r;
  logic signed [15:0] m00_r, m01_r, m02_r, m10_r, m11_r, m12_r, m20_r, m21_r, m22_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    m00_r <= in_m00; m01_r <= in_m01; m02_r <= in_m02;
    m10_r <= in_m10; m11_r <= in_m11; m12_r <= in_m12;
    m20_r <= in_m20; m21_r <= in_m21; m22_r <= in_m22;
  end

  // Branch selection, radicand and off-diagonal terms.
  logic signed [RW-1:0] tr, rad;
  logic signed [DW-1:0] d0, d1, d2;
  logic [1:0]           br;
  rmq_pkg::sq_tag_t     prep_tag;
  logic [NW-1:0]        prep_n;

  always_comb begin
    tr = RW'(m00_r) + RW'(m11_r) + RW'(m22_r);
    if (tr > 0) begin
      br  = rmq_pkg::BrW;
      rad = RW'(LimOne) + tr;
    end else if (m00_r > m11_r && m00_r > m22_r) begin
      br  = rmq_pkg::BrX;
      rad = RW'(LimOne) + RW'(m00_r) - RW'(m11_r) - RW'(m22_r);
    end else if (m11_r > m22_r) begin
      br  = rmq_pkg::BrY;
      rad = RW'(LimOne) + RW'(m11_r) - RW'(m00_r) - RW'(m22_r);
    end else begin
      br  = rmq_pkg::BrZ;
      rad = RW'(LimOne) + RW'(m22_r) - RW'(m00_r) - RW'(m11_r);
    end
    case (br)
      rmq_pkg::BrW: begin
        d0 = DW'(m21_r) - DW'(m12_r);
        d1 = DW'(m02_r) - DW'(m20_r);
        d2 = DW'(m10_r) - DW'(m01_r);
      end
      rmq_pkg::BrX: begin
        d0 = DW'(m21_r) - DW'(m12_r);
        d1 = DW'(m01_r) + DW'(m10_r);
        d2 = DW'(m02_r) + DW'(m20_r);
      end
      rmq_pkg::BrY: begin
        d0 = DW'(m02_r) - DW'(m20_r);
        d1 = DW'(m01_r) + DW'(m10_r);
        d2 = DW'(m12_r) + DW'(m21_r);
      end
      default: begin
        d0 = DW'(m10_r) - DW'(m01_r);
        d1 = DW'(m02_r) + DW'(m20_r);
        d2 = DW'(m12_r) + DW'(m21_r);
      end
    endcase
    prep_tag.bad  = rad[RW-1] || (rad == '0);
    prep_tag.br   = br;
    prep_tag.neg  = {d2[DW-1], d1[DW-1], d0[DW-1]};
    prep_tag.mag0 = d0[DW-1] ? MagW'(-d0) : MagW'(d0);
    prep_tag.mag1 = d1[DW-1] ? MagW'(-d1) : MagW'(d1);
    prep_tag.mag2 = d2[DW-1] ? MagW'(-d2) : MagW'(d2);
    prep_n = NW'(rad[rmq_pkg::RMagW-1:0]) << rmq_pkg::NShift;
  end

  // Square root pipeline: one root bit per stage.
  logic [SqS:0]      sq_vld_r;
  logic [SqRemW-1:0] sq_rem_r  [0:SqS];
  logic [HW-1:0]     sq_root_r [0:SqS];
  logic [NW-1:0]     sq_n_r    [0:SqS];
  rmq_pkg::sq_tag_t  sq_tag_r  [0:SqS];

  logic [SqRemW-1:0] sq_rem_nxt  [0:SqS-1];
  logic [HW-1:0]     sq_root_nxt [0:SqS-1];
  logic [NW-1:0]     sq_n_nxt    [0:SqS-1];

  always_comb begin
    for (int k = 0; k < SqS; k++) begin
      logic [SqRemW+1:0] rem_sh;
      logic [SqRemW+1:0] trial;
      logic              ge;
      rem_sh = {sq_rem_r[k], sq_n_r[k][NW-1 -: 2]};
      trial  = {2'b00, sq_root_r[k], 2'b01};
      ge     = rem_sh >= trial;
      sq_rem_nxt[k]  = ge ? SqRemW'(rem_sh - trial) : rem_sh[SqRemW-1:0];
      sq_root_nxt[k] = {sq_root_r[k][HW-2:0], ge};
      sq_n_nxt[k]    = sq_n_r[k] << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= '0;
    end else begin
      sq_vld_r <= {sq_vld_r[SqS-1:0], in_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    sq_rem_r[0]  <= '0;
    sq_root_r[0] <= '0;
    sq_n_r[0]    <= prep_n;
    sq_tag_r[0]  <= prep_tag;
    for (int k = 0; k < SqS; k++) begin
      sq_rem_r[k+1]  <= sq_rem_nxt[k];
      sq_root_r[k+1] <= sq_root_nxt[k];
      sq_n_r[k+1]    <= sq_n_nxt[k];
      sq_tag_r[k+1]  <= sq_tag_r[k];
    end
  end

  // Root rounding, branch component and divider setup.
  logic [HW-1:0]    h_rnd;
  logic [HW:0]      qtr_raw;
  rmq_pkg::dv_tag_t rnd_tag;
  logic [NumW-1:0]  num0, num1, num2;

  always_comb begin
    h_rnd   = sq_root_r[SqS] +
              HW'(sq_rem_r[SqS] > SqRemW'(sq_root_r[SqS]));
    qtr_raw = ((HW+1)'(h_rnd) + (HW+1)'(1 << (rmq_pkg::RoundSh - 1))) >> rmq_pkg::RoundSh;
    rnd_tag.bad     = sq_tag_r[SqS].bad;
    rnd_tag.br      = sq_tag_r[SqS].br;
    rnd_tag.neg     = sq_tag_r[SqS].neg;
    rnd_tag.quarter = (qtr_raw > (HW+1)'(rmq_pkg::LimInt)) ? rmq_pkg::Lim : qtr_raw[15:0];
    rnd_tag.dvsr    = {h_rnd, 1'b0};
    num0 = (NumW'(sq_tag_r[SqS].mag0) << rmq_pkg::SqrtFrac) + NumW'(h_rnd);
    num1 = (NumW'(sq_tag_r[SqS].mag1) << rmq_pkg::SqrtFrac) + NumW'(h_rnd);
    num2 = (NumW'(sq_tag_r[SqS].mag2) << rmq_pkg::SqrtFrac) + NumW'(h_rnd);
  end

  // Divider pipeline: three lanes, one quotient bit per stage.
  logic [QW:0]      dv_vld_r;
  logic [DvW-1:0]   dv_rem_r [0:QW][0:2];
  logic [QW-1:0]    dv_n_r   [0:QW][0:2];
  logic [QW-1:0]    dv_q_r   [0:QW][0:2];
  rmq_pkg::dv_tag_t dv_tag_r [0:QW];

  logic [DvW-1:0]   dv_rem_nxt [0:QW-1][0:2];
  logic [QW-1:0]    dv_n_nxt   [0:QW-1][0:2];
  logic [QW-1:0]    dv_q_nxt   [0:QW-1][0:2];

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      for (int j = 0; j < 3; j++) begin
        logic [DvW:0] rem_sh;
        logic         ge;
        rem_sh = {dv_rem_r[k][j], dv_n_r[k][j][QW-1]};
        ge     = rem_sh >= {1'b0, dv_tag_r[k].dvsr};
        dv_rem_nxt[k][j] = ge ? DvW'(rem_sh - {1'b0, dv_tag_r[k].dvsr}) : rem_sh[DvW-1:0];
        dv_q_nxt[k][j]   = {dv_q_r[k][j][QW-2:0], ge};
        dv_n_nxt[k][j]   = dv_n_r[k][j] << 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r <= '0;
    end else begin
      dv_vld_r <= {dv_vld_r[QW-1:0], sq_vld_r[SqS]};
    end
  end

  always_ff @(posedge clk) begin
    dv_tag_r[0]    <= rnd_tag;
    dv_rem_r[0][0] <= DvW'(num0[NumW-1:QW]);
    dv_rem_r[0][1] <= DvW'(num1[NumW-1:QW]);
    dv_rem_r[0][2] <= DvW'(num2[NumW-1:QW]);
    dv_n_r[0][0]   <= num0[QW-1:0];
    dv_n_r[0][1]   <= num1[QW-1:0];
    dv_n_r[0][2]   <= num2[QW-1:0];
    for (int j = 0; j < 3; j++) begin
      dv_q_r[0][j] <= '0;
    end
    for (int k = 0; k < QW; k++) begin
      dv_tag_r[k+1] <= dv_tag_r[k];
      for (int j = 0; j < 3; j++) begin
        dv_rem_r[k+1][j] <= dv_rem_nxt[k][j];
        dv_n_r[k+1][j]   <= dv_n_nxt[k][j];
        dv_q_r[k+1][j]   <= dv_q_nxt[k][j];
      end
    end
  end

  // Sign, saturation and placement of the four components.
  logic [15:0] lane_sat [0:2];
  logic [15:0] lane_val [0:2];
  logic [15:0] qw_nxt, qx_nxt, qy_nxt, qz_nxt;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      lane_sat[j] = rmq_pkg::sat_q(dv_q_r[QW][j]);
      lane_val[j] = dv_tag_r[QW].neg[j] ? -lane_sat[j] : lane_sat[j];
    end
    case (dv_tag_r[QW].br)
      rmq_pkg::BrW: begin
        qw_nxt = dv_tag_r[QW].quarter; qx_nxt = lane_val[0];
        qy_nxt = lane_val[1];          qz_nxt = lane_val[2];
      end
      rmq_pkg::BrX: begin
        qw_nxt = lane_val[0];          qx_nxt = dv_tag_r[QW].quarter;
        qy_nxt = lane_val[1];          qz_nxt = lane_val[2];
      end
      rmq_pkg::BrY: begin
        qw_nxt = lane_val[0];          qx_nxt = lane_val[1];
        qy_nxt = dv_tag_r[QW].quarter; qz_nxt = lane_val[2];
      end
      default: begin
        qw_nxt = lane_val[0];          qx_nxt = lane_val[1];
        qy_nxt = lane_val[2];          qz_nxt = dv_tag_r[QW].quarter;
      end
    endcase
    if (dv_tag_r[QW].bad) begin
      qw_nxt = '0; qx_nxt = '0; qy_nxt = '0; qz_nxt = '0;
    end
  end

  // Output register with its strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv_vld_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    out_qw        <= qw_nxt;
    out_qx        <= qx_nxt;
    out_qy        <= qy_nxt;
    out_qz        <= qz_nxt;
    out_bad_input <= dv_tag_r[QW].bad;
  end

  // A rejected radicand gives an all-zero quaternion.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_input |-> out_qw == 0 && out_qx == 0 && out_qy == 0 && out_qz == 0)
    else $error("bad input result is not zero");

  // The w and x parts stay within the saturation limit.
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_qw <= $signed(rmq_pkg::Lim) && out_qw >= -$signed(rmq_pkg::Lim) &&
                  out_qx <= $signed(rmq_pkg::Lim) && out_qx >= -$signed(rmq_pkg::Lim))
    else $error("quaternion part beyond limit");

  // A square root leaving the pipeline always enters the divider on the next edge.
  a_sq_to_dv: assert property (@(posedge clk) disable iff (!rst_n)
    sq_vld_r[SqS] |=> dv_vld_r[0])
    else $error("transaction lost between square root and divider");

  // An accepted transaction enters the pipeline on the next edge.
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> in_vld_r)
    else $error("accepted transaction not captured");

endmodule
`default_nettype wire
